### design/lcd_pkg.sv
`timescale 1ns / 1ps

package lcd_pkg;

    localparam int NEST_MAX_DEFAULT = 127;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_I  = 8'h69;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [1:0] {
        ST_OUT    = 2'd0,
        ST_OPEN   = 2'd1,
        ST_SINGLE = 2'd2,
        ST_MULTI  = 2'd3
    } str_state_t;

    typedef struct packed {
        str_state_t sstate;
        logic [7:0] open_quote;
        logic [1:0] quote_run;
        logic       escape_pending;
        logic [7:0] tail0;
        logic [7:0] tail1;
        logic [7:0] tail2;
        logic [1:0] tail_valid;
        logic       ws_gap;
    } scan_state_t;

    typedef struct packed {
        logic need_more;
        logic in_string;
        logic multi_string;
    } scan_flags_t;

    // signed counter width: holds +/-nest_max, never narrower than the 8-bit outputs
    function automatic int cnt_width(input int nest_max);
        int w;
        w = $clog2(nest_max + 1) + 1;
        return (w > 8) ? w : 8;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
               (c == CH_BSLASH) || (c == 8'h25) || (c == 8'h5E) || (c == 8'h2C) ||
               (c == 8'h3D) || (c == 8'h2E) || (c == 8'h3A) || (c == 8'h3F) ||
               (c == 8'h7C) || (c == 8'h26) || (c == 8'h3C) || (c == 8'h3E) ||
               (c == 8'h21);
    endfunction

endpackage

### design/lcd_scan.sv
`timescale 1ns / 1ps

module lcd_scan #(
    parameter int NEST_MAX = lcd_pkg::NEST_MAX_DEFAULT
) (
    input  lcd_pkg::scan_state_t                             cur,
    input  logic signed [lcd_pkg::cnt_width(NEST_MAX)-1:0]   brace_cur,
    input  logic signed [lcd_pkg::cnt_width(NEST_MAX)-1:0]   paren_cur,
    input  logic signed [lcd_pkg::cnt_width(NEST_MAX)-1:0]   bracket_cur,
    input  logic [7:0]                                       ch,
    input  logic                                             first,
    output lcd_pkg::scan_state_t                             nxt,
    output logic signed [lcd_pkg::cnt_width(NEST_MAX)-1:0]   brace_nxt,
    output logic signed [lcd_pkg::cnt_width(NEST_MAX)-1:0]   paren_nxt,
    output logic signed [lcd_pkg::cnt_width(NEST_MAX)-1:0]   bracket_nxt,
    output lcd_pkg::scan_flags_t                             flags
);
    import lcd_pkg::*;

    localparam int CNT_W = cnt_width(NEST_MAX);
    localparam logic signed [CNT_W-1:0] CNT_MAX = CNT_W'(NEST_MAX);
    localparam logic signed [CNT_W-1:0] CNT_MIN = -CNT_W'(NEST_MAX);
    localparam logic signed [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    scan_state_t              s;
    logic signed [CNT_W-1:0]  br, pa, bk;
    logic                     do_outside;
    logic                     do_single;
    logic                     tail_more;
    logic                     in_str;
    logic                     multi;

    always_comb
    begin
        if (first)
        begin
            s  = '0;
            br = '0;
            pa = '0;
            bk = '0;
        end
        else
        begin
            s  = cur;
            br = brace_cur;
            pa = paren_cur;
            bk = bracket_cur;
        end

        do_outside = 1'b0;
        do_single  = 1'b0;

        unique case (s.sstate)
            ST_OUT:
            begin
                do_outside = 1'b1;
            end
            ST_OPEN:
            begin
                if (ch == s.open_quote)
                begin
                    if (s.quote_run == 2'd1)
                    begin
                        s.quote_run = 2'd2;
                    end
                    else
                    begin
                        s.sstate    = ST_MULTI;
                        s.quote_run = 2'd0;
                    end
                end
                else if (s.quote_run == 2'd1)
                begin
                    s.sstate    = ST_SINGLE;
                    s.quote_run = 2'd0;
                    do_single   = 1'b1;
                end
                else
                begin
                    // two quotes were an empty string; rescan this byte outside
                    s.sstate    = ST_OUT;
                    s.quote_run = 2'd0;
                    do_outside  = 1'b1;
                end
            end
            ST_SINGLE:
            begin
                do_single = 1'b1;
            end
            ST_MULTI:
            begin
                if (s.escape_pending)
                begin
                    s.escape_pending = 1'b0;
                    s.quote_run      = 2'd0;
                end
                else if (ch == CH_BSLASH)
                begin
                    s.escape_pending = 1'b1;
                    s.quote_run      = 2'd0;
                end
                else if (ch == s.open_quote)
                begin
                    if (s.quote_run == 2'd2)
                    begin
                        s.sstate    = ST_OUT;
                        s.quote_run = 2'd0;
                    end
                    else
                    begin
                        s.quote_run = s.quote_run + 2'd1;
                    end
                end
                else
                begin
                    s.quote_run = 2'd0;
                end
            end
            default:
            begin
                do_outside = 1'b1;
            end
        endcase

        if (do_single)
        begin
            if (s.escape_pending)
                s.escape_pending = 1'b0;
            else if (ch == CH_BSLASH)
                s.escape_pending = 1'b1;
            else if (ch == s.open_quote)
                s.sstate = ST_OUT;
        end

        if (do_outside)
        begin
            if ((ch == CH_DQUOTE) || (ch == CH_SQUOTE))
            begin
                s.sstate     = ST_OPEN;
                s.open_quote = ch;
                s.quote_run  = 2'd1;
            end
            else if ((ch == CH_LBRACE) && (br != CNT_MAX))
                br = br + CNT_ONE;
            else if ((ch == CH_RBRACE) && (br != CNT_MIN))
                br = br - CNT_ONE;
            else if ((ch == CH_LPAREN) && (pa != CNT_MAX))
                pa = pa + CNT_ONE;
            else if ((ch == CH_RPAREN) && (pa != CNT_MIN))
                pa = pa - CNT_ONE;
            else if ((ch == CH_LBRACK) && (bk != CNT_MAX))
                bk = bk + CNT_ONE;
            else if ((ch == CH_RBRACK) && (bk != CNT_MIN))
                bk = bk - CNT_ONE;
        end

        // tail keeps last non-blank byte plus two before it, a gap folded to one space
        if (is_space(ch))
        begin
            if (s.tail_valid != 2'd0)
                s.ws_gap = 1'b1;
        end
        else
        begin
            if (s.ws_gap)
            begin
                s.tail2 = s.tail1;
                s.tail1 = s.tail0;
                s.tail0 = CH_SPACE;
                if (s.tail_valid != 2'd3)
                    s.tail_valid = s.tail_valid + 2'd1;
            end
            s.ws_gap = 1'b0;
            s.tail2  = s.tail1;
            s.tail1  = s.tail0;
            s.tail0  = ch;
            if (s.tail_valid != 2'd3)
                s.tail_valid = s.tail_valid + 2'd1;
        end
    end

    always_comb
    begin
        tail_more = 1'b0;
        if (s.tail_valid != 2'd0)
        begin
            if (is_op(s.tail0))
                tail_more = 1'b1;
            else if ((s.tail_valid != 2'd1) && (s.tail0 == CH_LOW_N) &&
                     (s.tail1 == CH_LOW_I))
                tail_more = (s.tail_valid != 2'd3) || !is_word(s.tail2);
        end
    end

    assign in_str = (s.sstate == ST_SINGLE) || (s.sstate == ST_MULTI) ||
                    ((s.sstate == ST_OPEN) && (s.quote_run == 2'd1));
    assign multi  = (s.sstate == ST_MULTI);

    assign flags.need_more    = (br > 0) || (pa > 0) || (bk > 0) || (in_str && multi) ||
                                (!in_str && tail_more);
    assign flags.in_string    = in_str;
    assign flags.multi_string = multi;

    assign nxt         = s;
    assign brace_nxt   = br;
    assign paren_nxt   = pa;
    assign bracket_nxt = bk;

endmodule

### design/line_continuation_detector.sv
`timescale 1ns / 1ps
// An accepted byte is held in the input register, then the scan logic writes its result
//   into the result register; the scan state loop closes through combinational logic.
// Throughput: one byte per cycle, unless a line-end byte waits on an unread result.
// A result is produced only for bytes with tlast set; results wait in the output register.
// Reset (rst_n low, asynchronous): pipeline empty, depths zero, outside any string, tail empty.
module line_continuation_detector #(
    parameter int NEST_MAX = lcd_pkg::NEST_MAX_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic        s_tuser,   // first
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // need_more[0], brace_depth[8:1], paren_depth[16:9],
                                   // bracket_depth[24:17], in_string[25], multi_string[26]
);
    import lcd_pkg::*;

    localparam int CNT_W = cnt_width(NEST_MAX);

    logic                     in_valid_reg, in_valid_next;
    logic [7:0]               in_ch_reg;
    logic                     in_first_reg;
    logic                     in_last_reg;

    scan_state_t              st_reg;
    scan_state_t              st_next;
    logic signed [CNT_W-1:0]  brace_reg, brace_next;
    logic signed [CNT_W-1:0]  paren_reg, paren_next;
    logic signed [CNT_W-1:0]  bracket_reg, bracket_next;
    scan_flags_t              flags;

    logic                     out_valid_reg, out_valid_next;
    logic [31:0]              out_data_reg, out_data_next;

    logic                     s_accept;
    logic                     advance;

    lcd_scan #(
        .NEST_MAX (NEST_MAX)
    ) u_scan (
        .cur         (st_reg),
        .brace_cur   (brace_reg),
        .paren_cur   (paren_reg),
        .bracket_cur (bracket_reg),
        .ch          (in_ch_reg),
        .first       (in_first_reg),
        .nxt         (st_next),
        .brace_nxt   (brace_next),
        .paren_nxt   (paren_next),
        .bracket_nxt (bracket_next),
        .flags       (flags)
    );

    // a byte without line end never needs the output register
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        out_data_next = {5'd0, flags.multi_string, flags.in_string,
                         bracket_next[7:0], paren_next[7:0], brace_next[7:0],
                         flags.need_more};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            brace_reg     <= '0;
            paren_reg     <= '0;
            bracket_reg   <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg      <= st_next;
                brace_reg   <= brace_next;
                paren_reg   <= paren_next;
                bracket_reg <= bracket_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_ch_reg    <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (advance && in_last_reg)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### sim/line_continuation_detector_tb.sv
`timescale 1ns / 1ps

module line_continuation_detector_tb;

    import lcd_pkg::*;

    localparam int NEST = NEST_MAX_DEFAULT;

    typedef struct packed {
        logic       multi_string;
        logic       in_string;
        logic [7:0] bracket_depth;
        logic [7:0] paren_depth;
        logic [7:0] brace_depth;
        logic       need_more;
    } line_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    line_continuation_detector dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // scanner state mirrored from the accepted byte stream
    int         br_depth;
    int         pr_depth;
    int         bk_depth;
    str_state_t qstate;
    bit [7:0]   quote_ch;
    int         qrun;
    bit         esc_armed;
    bit [7:0]   tail_buf [3];
    int         tail_cnt;
    bit         ws_seen;
    bit         last_more;

    line_status_t pending_status [$];
    line_status_t want_status;
    logic [7:0]   line_buf [$];
    int           errors = 0;
    bit           src_idle = 1'b1;
    bit           snk_idle = 1'b1;

    string ops    = "+-*/\\%^,=.:?|&<>!";
    string opens  = "{([";
    string closes = "})]";
    string blanks = " \t\r\n";

    function automatic bit blank_byte(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic bit ident_byte(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic bit op_byte(input logic [7:0] c);
        for (int i = 0; i < ops.len(); i++)
            if (ops[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic int clip_depth(input int v);
        if (v > NEST)
            return NEST;
        if (v < -NEST)
            return -NEST;
        return v;
    endfunction

    function automatic void clear_scanner();
        br_depth = 0;
        pr_depth = 0;
        bk_depth = 0;
        qstate = ST_OUT;
        quote_ch = 8'h00;
        qrun = 0;
        esc_armed = 1'b0;
        tail_buf = '{8'h00, 8'h00, 8'h00};
        tail_cnt = 0;
        ws_seen = 1'b0;
    endfunction

    function automatic void outside_byte(input logic [7:0] c);
        case (c)
            CH_DQUOTE, CH_SQUOTE:
            begin
                qstate = ST_OPEN;
                quote_ch = c;
                qrun = 1;
            end
            CH_LBRACE: br_depth = clip_depth(br_depth + 1);
            CH_RBRACE: br_depth = clip_depth(br_depth - 1);
            CH_LPAREN: pr_depth = clip_depth(pr_depth + 1);
            CH_RPAREN: pr_depth = clip_depth(pr_depth - 1);
            CH_LBRACK: bk_depth = clip_depth(bk_depth + 1);
            CH_RBRACK: bk_depth = clip_depth(bk_depth - 1);
            default: ;
        endcase
    endfunction

    function automatic void single_byte(input logic [7:0] c);
        if (esc_armed)
            esc_armed = 1'b0;
        else if (c == CH_BSLASH)
            esc_armed = 1'b1;
        else if (c == quote_ch)
            qstate = ST_OUT;
    endfunction

    // closing run of three quotes ends a triple-quoted string
    function automatic void multi_byte(input logic [7:0] c);
        if (esc_armed)
        begin
            esc_armed = 1'b0;
            qrun = 0;
        end
        else if (c == CH_BSLASH)
        begin
            esc_armed = 1'b1;
            qrun = 0;
        end
        else if (c == quote_ch)
        begin
            qrun++;
            if (qrun >= 3)
            begin
                qstate = ST_OUT;
                qrun = 0;
            end
        end
        else
            qrun = 0;
    endfunction

    // one quote then other: single string; two then other: empty string, closed
    function automatic void opening_byte(input logic [7:0] c);
        if (c == quote_ch)
        begin
            if (qrun == 1)
                qrun = 2;
            else
            begin
                qstate = ST_MULTI;
                qrun = 0;
            end
        end
        else if (qrun == 1)
        begin
            qstate = ST_SINGLE;
            qrun = 0;
            single_byte(c);
        end
        else
        begin
            qstate = ST_OUT;
            qrun = 0;
            outside_byte(c);
        end
    endfunction

    function automatic void push_tail(input logic [7:0] c);
        tail_buf[2] = tail_buf[1];
        tail_buf[1] = tail_buf[0];
        tail_buf[0] = c;
        if (tail_cnt < 3)
            tail_cnt++;
    endfunction

    function automatic void note_tail(input logic [7:0] c);
        if (blank_byte(c))
        begin
            if (tail_cnt > 0)
                ws_seen = 1'b1;
            return;
        end
        if (ws_seen)
            push_tail(CH_SPACE);
        ws_seen = 1'b0;
        push_tail(c);
    endfunction

    function automatic bit tail_wants_more();
        if (tail_cnt == 0)
            return 1'b0;
        if (op_byte(tail_buf[0]))
            return 1'b1;
        if (tail_cnt >= 2 && tail_buf[0] == CH_LOW_N && tail_buf[1] == CH_LOW_I)
            return tail_cnt < 3 || !ident_byte(tail_buf[2]);
        return 1'b0;
    endfunction

    function automatic void advance_scanner(input logic [7:0] c, input bit f, input bit le);
        line_status_t st;
        bit           in_str;
        bit           multi;
        if (f)
            clear_scanner();
        case (qstate)
            ST_OUT:    outside_byte(c);
            ST_OPEN:   opening_byte(c);
            ST_SINGLE: single_byte(c);
            default:   multi_byte(c);
        endcase
        note_tail(c);
        if (!le)
            return;
        in_str = qstate == ST_SINGLE || qstate == ST_MULTI || (qstate == ST_OPEN && qrun == 1);
        multi = qstate == ST_MULTI;
        st.need_more = br_depth > 0 || pr_depth > 0 || bk_depth > 0 ||
                       (in_str && multi) || (!in_str && tail_wants_more());
        st.brace_depth = br_depth[7:0];
        st.paren_depth = pr_depth[7:0];
        st.bracket_depth = bk_depth[7:0];
        st.in_string = in_str;
        st.multi_string = multi;
        pending_status.insert(pending_status.size(), st);
        last_more = st.need_more;
    endfunction

    task automatic send_byte(input logic [7:0] c, input bit f, input bit le);
        int gap;
        gap = src_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= f;
        s_tlast  <= le;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_scanner(c, f, le);
    endtask

    task automatic send_text(input string s, input bit f);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], f && i == 0, i == s.len() - 1);
    endtask

    function automatic logic [7:0] ident_char();
        case ($urandom_range(0, 3))
            0: return 8'("a" + $urandom_range(0, 25));
            1: return 8'("A" + $urandom_range(0, 25));
            2: return 8'("0" + $urandom_range(0, 9));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic void add_byte(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    task automatic build_line();
        logic [7:0] q;
        line_buf.delete();
        repeat ($urandom_range(1, 6))
        begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            case ($urandom_range(0, 15))
                0, 1: repeat ($urandom_range(1, 4)) add_byte(ident_char());
                2:
                begin
                    add_byte(CH_LOW_I);
                    add_byte(CH_LOW_N);
                end
                3:
                begin
                    add_byte($urandom_range(0, 1) ? ident_char() : CH_SPACE);
                    add_byte(CH_LOW_I);
                    add_byte(CH_LOW_N);
                end
                4, 5: repeat ($urandom_range(1, 3))
                    add_byte(blanks[$urandom_range(0, 3)]);
                6, 7: add_byte(ops[$urandom_range(0, ops.len() - 1)]);
                8: add_byte(opens[$urandom_range(0, 2)]);
                9: add_byte(closes[$urandom_range(0, 2)]);
                10: repeat ($urandom_range(1, 3)) add_byte(q);
                11:
                begin
                    add_byte(q);
                    repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(32, 126)));
                    add_byte(q);
                end
                12:
                begin
                    repeat (3) add_byte(q);
                    repeat ($urandom_range(0, 6))
                        add_byte($urandom_range(0, 2) == 0 ? q :
                                 8'($urandom_range(32, 126)));
                    repeat ($urandom_range(0, 3)) add_byte(q);
                end
                13: add_byte(CH_BSLASH);
                14: add_byte(8'($urandom_range(0, 255)));
                default:
                begin
                    add_byte(CH_SPACE);
                    add_byte(CH_LOW_I);
                    add_byte(CH_LOW_N);
                end
            endcase
        end
        if ($urandom_range(0, 1))
            add_byte(CH_LF);
    endtask

    task automatic test_directed_cases();
        src_idle = 1'b1;
        snk_idle = 1'b1;
        send_text("(", 1'b1);           // new entry and line end on one byte
        send_text("'", 1'b1);           // lone quote leaves a string open
        send_text("\"\"", 1'b1);        // empty string, closed
        send_text("\"\"(", 1'b1);       // byte after empty string is outside
        send_text("'''", 1'b1);         // triple quote opens
        send_text("''", 1'b0);          // two closers only: still open
        send_text("'", 1'b0);
        send_text("\"\\", 1'b1);        // trailing backslash inside string
        send_text("\"", 1'b0);          // escaped, string stays open
        send_text(" in", 1'b1);
        send_text("},", 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_depth_saturation();
        src_idle = 1'b0;
        snk_idle = 1'b1;
        for (int i = 0; i < 390; i++)
            send_byte(opens[i % 3], i == 0, i % 40 == 39 || i == 389);
        // one close right after saturation must step back from the limit
        send_text("})]", 1'b0);
        src_idle = 1'b1;
        snk_idle = 1'b0;
        for (int i = 0; i < 390; i++)
            send_byte(closes[i % 3], i == 0, i % 40 == 39 || i == 389);
        send_text("{([", 1'b0);
    endtask

    task automatic test_random_entries(input int n_bytes);
        int sent;
        int lines_in_entry;
        bit start;
        bit f;
        sent = 0;
        start = 1'b1;
        lines_in_entry = 0;
        while (sent < n_bytes)
        begin
            if (start)
            begin
                src_idle = $urandom_range(0, 3) != 0;
                snk_idle = $urandom_range(0, 3) != 0;
                lines_in_entry = 0;
            end
            build_line();
            foreach (line_buf[i])
            begin
                // a stray entry start mid-line now and then
                f = (start && i == 0) || $urandom_range(0, 99) == 0;
                send_byte(line_buf[i], f, i == line_buf.size() - 1);
            end
            sent += line_buf.size();
            lines_in_entry++;
            start = !last_more || lines_in_entry >= 6 || $urandom_range(0, 9) == 0;
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] exp,
                                        input logic [7:0] act);
        if (act !== exp)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: result with none pending, expected none, actual %h",
                         $time, m_tdata);
                errors++;
            end
            else
            begin
                want_status = pending_status.pop_front();
                check_field("need_more", 8'(want_status.need_more), 8'(m_tdata[0]));
                check_field("brace_depth", want_status.brace_depth, m_tdata[8:1]);
                check_field("paren_depth", want_status.paren_depth, m_tdata[16:9]);
                check_field("bracket_depth", want_status.bracket_depth, m_tdata[24:17]);
                check_field("in_string", 8'(want_status.in_string), 8'(m_tdata[25]));
                check_field("multi_string", 8'(want_status.multi_string), 8'(m_tdata[26]));
                check_field("tdata pad", 8'h00, 8'(m_tdata[31:27]));
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        clear_scanner();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_depth_saturation();
        test_random_entries(1000);
        s_tvalid <= 1'b0;
        snk_idle = 1'b0;
        wait (pending_status.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
design/lcd_pkg.sv
design/lcd_scan.sv
design/line_continuation_detector.sv
sim/line_continuation_detector_tb.sv
